// ----- design/bfmc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bfmc_pkg
// Shared codes for the buffer frame manager.
// ----------------------------------------------------------------------------
package bfmc_pkg;
    localparam int FRAMES = 16;

    localparam logic [2:0] ACT_PIN     = 3'd0;
    localparam logic [2:0] ACT_UNPIN   = 3'd1;
    localparam logic [2:0] ACT_FLUSH_F = 3'd2;
    localparam logic [2:0] ACT_FLUSH_A = 3'd3;
    localparam logic [2:0] ACT_RELEASE = 3'd4;

    localparam logic [1:0] KIND_WB   = 2'd0;
    localparam logic [1:0] KIND_RD   = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_STORE = 3'd1;
    localparam logic [2:0] ST_ALL_PIN  = 3'd2;
    localparam logic [2:0] ST_NOT_RES  = 3'd3;
    localparam logic [2:0] ST_ZERO_PIN = 3'd4;
    localparam logic [2:0] ST_PINNED   = 3'd5;
endpackage
`default_nettype wire

// ----- design/buffer_frame_manager_clock_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// buffer_frame_manager_clock_core
// Page-frame table with pin counts and CLOCK replacement.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_        in   s_valid/s_ready    action, file_id, page_id, dirty_flag
// m_        out  m_valid/m_ready    kind, req_file, req_page, frame_num, hit,
//                                   status, last
// apb       in   psel/penable       store_present_mask at address 0
// One request at a time, taken only once the previous result has left. Frame
// file/page/pins sit in a memory with registered read; every walk (lookup,
// sweep, flush, release) reads a frame, then checks it. Pin: lookup over the
// frames until a hit, then a sweep of up to 2*FRAMES frame visits. Flush and
// release walk every frame, ending early on a fault. Reset clears the mark
// bits at once; no clearing pass. Output register stalls walks while m_ready low.
// ----------------------------------------------------------------------------
module buffer_frame_manager_clock_core #(
    parameter int PIN_BITS = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire         paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [2:0]  s_action,
    input  wire  [2:0]  s_file_id,
    input  wire  [31:0] s_page_id,
    input  wire         s_dirty_flag,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_kind,
    output logic [2:0]  m_req_file,
    output logic [31:0] m_req_page,
    output logic [3:0]  m_frame_num,
    output logic        m_hit,
    output logic [2:0]  m_status,
    output logic        m_last
);
    import bfmc_pkg::*;

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(2 * FRAMES + 1);
    localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE, S_LK_RD, S_LK_CHK, S_SW_RD, S_SW_CHK, S_EVICT,
        S_WK_RD, S_WK_CHK, S_OUT, S_DONE
    } state_t;

    // frame memory: file/page/pins, marks in flops
    logic [2:0]          mem_file [FRAMES];
    logic [31:0]         mem_page [FRAMES];
    logic [PIN_BITS-1:0] mem_pins [FRAMES];
    logic [FRAMES-1:0]   valid_reg, dirty_reg, ref_reg;

    logic [2:0]          rd_file;
    logic [31:0]         rd_page;
    logic [PIN_BITS-1:0] rd_pins;
    logic [IW-1:0]       rd_addr;
    logic                we;
    logic [IW-1:0]       wa;
    logic [2:0]          wd_file;
    logic [31:0]         wd_page;
    logic [PIN_BITS-1:0] wd_pins;

    state_t        state_reg;
    logic [7:0]    mask_reg;
    logic [IW-1:0] hand_reg, idx_reg;
    logic [CW-1:0] cnt_reg;
    logic [2:0]    act_reg, file_reg;
    logic [31:0]   page_reg;
    logic          dflag_reg;
    logic          ret_reg; // after S_OUT: 0 continue to evict, 1 go to done
    logic [IW-1:0] vic_reg;
    logic          put_reg, take_reg; // result valid = put ^ take

    logic          last_idx;
    logic [IW-1:0] idx_inc, hand_inc;
    logic          store_of_rd, store_of_req;
    logic          wk_rel, wk_fl, wk_pinned, wk_fault;
    logic          mask_clr;

    assign pready = 1'b1;
    assign prdata = {24'd0, mask_reg};
    assign m_valid = put_reg ^ take_reg;
    assign s_ready = (state_reg == S_IDLE) && !m_valid;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_file[wa] <= wd_file;
            mem_page[wa] <= wd_page;
            mem_pins[wa] <= wd_pins;
        end
        rd_file <= mem_file[rd_addr];
        rd_page <= mem_page[rd_addr];
        rd_pins <= mem_pins[rd_addr];
    end

    assign last_idx = (idx_reg == IW'(FRAMES - 1));
    assign idx_inc  = last_idx ? '0 : idx_reg + 1'b1;
    assign hand_inc = (hand_reg == IW'(FRAMES - 1)) ? '0 : hand_reg + 1'b1;
    assign store_of_rd  = mask_reg[rd_file];
    assign store_of_req = mask_reg[file_reg];

    assign wk_rel    = (act_reg == ACT_RELEASE) && valid_reg[idx_reg] && (rd_file == file_reg);
    assign wk_fl     = (act_reg != ACT_RELEASE) && valid_reg[idx_reg] && dirty_reg[idx_reg]
                       && (act_reg == ACT_FLUSH_A || rd_file == file_reg);
    assign wk_pinned = wk_rel && (rd_pins != '0);
    assign wk_fault  = wk_pinned
                       || ((wk_rel || wk_fl) && dirty_reg[idx_reg] && !store_of_rd);
    assign mask_clr  = (state_reg == S_DONE) && (!m_valid || m_ready)
                       && (act_reg == ACT_RELEASE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else if (psel && penable && pwrite && !paddr) begin
            mask_reg <= pwdata[7:0];
        end else if (mask_clr) begin
            mask_reg[file_reg] <= 1'b0;
        end
    end

    always_comb begin
        rd_addr = (state_reg == S_SW_RD) ? hand_reg : idx_reg;
        we = 1'b0;
        wa = idx_reg;
        wd_file = rd_file;
        wd_page = rd_page;
        wd_pins = rd_pins;
        unique case (state_reg)
            S_LK_CHK: begin
                if (act_reg == ACT_PIN && valid_reg[idx_reg] && rd_file == file_reg
                    && rd_page == page_reg) begin
                    we = 1'b1;
                    wd_pins = (rd_pins == PIN_MAX) ? rd_pins : rd_pins + 1'b1;
                end else if (act_reg == ACT_UNPIN && valid_reg[idx_reg]
                    && rd_file == file_reg && rd_page == page_reg && rd_pins != '0) begin
                    we = 1'b1;
                    wd_pins = rd_pins - 1'b1;
                end
            end
            S_EVICT: begin
                wa = vic_reg;
                if (store_of_req) begin
                    we = 1'b1;
                    wd_file = file_reg;
                    wd_page = page_reg;
                    wd_pins = PIN_BITS'(1);
                end
            end
            default: ;
        endcase
    end

    task automatic emit(input logic [1:0] k, input logic [2:0] fl, input logic [31:0] pg,
                        input logic [IW-1:0] fi, input logic h, input logic [2:0] st);
        put_reg     <= ~put_reg;
        m_kind      <= k;
        m_req_file  <= fl;
        m_req_page  <= pg;
        m_frame_num <= 4'(fi);
        m_hit       <= h;
        m_status    <= st;
        m_last      <= (k == KIND_DONE);
    endtask

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            hand_reg  <= '0;
            valid_reg <= '0;
            dirty_reg <= '0;
            ref_reg   <= '0;
            put_reg   <= 1'b0;
            take_reg  <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                take_reg <= ~take_reg;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        act_reg   <= s_action;
                        file_reg  <= s_file_id;
                        page_reg  <= s_page_id;
                        dflag_reg <= s_dirty_flag;
                        idx_reg   <= '0;
                        cnt_reg   <= '0;
                        priority if (s_action == ACT_PIN || s_action == ACT_UNPIN) begin
                            state_reg <= S_LK_RD;
                        end else if (s_action == ACT_FLUSH_F || s_action == ACT_FLUSH_A
                                     || s_action == ACT_RELEASE) begin
                            state_reg <= S_WK_RD;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_LK_RD: state_reg <= S_LK_CHK;
                S_LK_CHK: begin
                    if (valid_reg[idx_reg] && rd_file == file_reg && rd_page == page_reg) begin
                        if (act_reg == ACT_PIN) begin
                            ref_reg[idx_reg] <= 1'b1;
                            emit(KIND_DONE, file_reg, page_reg, idx_reg, 1'b1, ST_OK);
                        end else if (rd_pins == '0) begin
                            emit(KIND_DONE, file_reg, page_reg, idx_reg, 1'b0, ST_ZERO_PIN);
                        end else begin
                            if (dflag_reg) dirty_reg[idx_reg] <= 1'b1;
                            emit(KIND_DONE, file_reg, page_reg, idx_reg, 1'b0, ST_OK);
                        end
                        state_reg <= S_IDLE;
                    end else if (last_idx) begin
                        if (act_reg == ACT_PIN) begin
                            state_reg <= S_SW_RD;
                        end else begin
                            emit(KIND_DONE, file_reg, page_reg, '0, 1'b0, ST_NOT_RES);
                            state_reg <= S_IDLE;
                        end
                    end else begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_LK_RD;
                    end
                end
                S_SW_RD: begin
                    vic_reg   <= hand_reg;
                    hand_reg  <= hand_inc;
                    cnt_reg   <= cnt_reg + 1'b1;
                    state_reg <= S_SW_CHK;
                end
                S_SW_CHK: begin
                    if (!valid_reg[vic_reg]) begin
                        state_reg <= S_EVICT;
                    end else if (rd_pins != '0 || ref_reg[vic_reg]) begin
                        if (rd_pins == '0) ref_reg[vic_reg] <= 1'b0;
                        if (cnt_reg == CW'(2 * FRAMES)) begin
                            emit(KIND_DONE, file_reg, page_reg, '0, 1'b0, ST_ALL_PIN);
                            state_reg <= S_IDLE;
                        end else begin
                            state_reg <= S_SW_RD;
                        end
                    end else if (dirty_reg[vic_reg] && !store_of_rd) begin
                        emit(KIND_DONE, file_reg, page_reg, vic_reg, 1'b0, ST_NO_STORE);
                        state_reg <= S_IDLE;
                    end else begin
                        if (dirty_reg[vic_reg]) begin
                            emit(KIND_WB, rd_file, rd_page, vic_reg, 1'b0, ST_OK);
                        end
                        valid_reg[vic_reg] <= 1'b0;
                        dirty_reg[vic_reg] <= 1'b0;
                        ref_reg[vic_reg]   <= 1'b0;
                        state_reg <= dirty_reg[vic_reg] ? S_OUT : S_EVICT;
                        ret_reg   <= 1'b0;
                    end
                end
                S_EVICT: begin
                    if (!m_valid || m_ready) begin
                        if (!store_of_req) begin
                            emit(KIND_DONE, file_reg, page_reg, vic_reg, 1'b0, ST_NO_STORE);
                            state_reg <= S_IDLE;
                        end else begin
                            emit(KIND_RD, file_reg, page_reg, vic_reg, 1'b0, ST_OK);
                            valid_reg[vic_reg] <= 1'b1;
                            dirty_reg[vic_reg] <= 1'b0;
                            ref_reg[vic_reg]   <= 1'b1;
                            idx_reg   <= vic_reg;
                            state_reg <= S_OUT;
                            ret_reg   <= 1'b1;
                        end
                    end
                end
                S_WK_RD: state_reg <= S_WK_CHK;
                S_WK_CHK: begin
                    if (!m_valid || m_ready) begin
                        idx_reg <= idx_inc;
                        if (wk_fault) begin
                            emit(KIND_DONE, file_reg, page_reg, idx_reg, 1'b0,
                                 wk_pinned ? ST_PINNED : ST_NO_STORE);
                            state_reg <= S_IDLE;
                        end else begin
                            state_reg <= last_idx ? S_DONE : S_WK_RD;
                            if (wk_rel || wk_fl) begin
                                if (dirty_reg[idx_reg]) begin
                                    emit(KIND_WB, rd_file, rd_page, idx_reg, 1'b0, ST_OK);
                                end
                                dirty_reg[idx_reg] <= 1'b0;
                            end
                            if (wk_rel) begin
                                valid_reg[idx_reg] <= 1'b0;
                                ref_reg[idx_reg]   <= 1'b0;
                            end
                        end
                    end
                end
                S_OUT: begin
                    if (!m_valid || m_ready) begin
                        if (ret_reg) begin
                            emit(KIND_DONE, file_reg, page_reg, idx_reg, 1'b0, ST_OK);
                            state_reg <= S_IDLE;
                        end else begin
                            state_reg <= S_EVICT;
                        end
                    end
                end
                S_DONE: begin
                    if (!m_valid || m_ready) begin
                        emit(KIND_DONE, file_reg, page_reg, '0, 1'b0, ST_OK);
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("accepted while busy");
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_kind == KIND_DONE))) else $error("last mismatch");
    a_req_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != KIND_DONE) |-> (m_status == ST_OK && !m_hit))
        else $error("request with status");
`endif
endmodule
`default_nettype wire
